// File: design/llss_pkg.sv
`default_nettype none
package llss_pkg;

	localparam int NUM_SERVERS = 3;
	localparam int SCAN_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

	localparam int TYPE_W = 1;
	localparam int INDEX_W = 2;
	localparam int LOAD_W = 20;
	localparam int AGE_W = 8;
	localparam int PORT_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;
	localparam logic [AGE_W-1:0] TIMEOUT_RESET = 8'd5;
	localparam logic [LOAD_W-1:0] CEILING_RESET = 20'd666666;
	localparam logic [PORT_W-1:0] PORT_BASE_RESET = 16'd10000;

	localparam int LATENCY = NUM_SERVERS + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIMEOUT = 2'd0,
		REG_CEILING = 2'd1,
		REG_PORT_BASE = 2'd2
	} reg_idx_t;

	typedef enum logic [TYPE_W-1:0] {
		REQ_TICK = 1'b0,
		REQ_HEARTBEAT = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic apply;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
	} sts_t;

endpackage
`default_nettype wire

// File: design/least_loaded_server_selector.sv
// Least-loaded server selector.
// Keeps alive/heard/load/age for each back-end server and reports the live
// server with the smallest load below the ceiling after every item.
// Input: start with req_type, server_index, reported_load; an item is taken
// at a clock edge where start is high and busy is low. req_type 1 is a
// heartbeat, 0 is a one-second tick.
// Output: done is high for exactly one cycle with chosen_server,
// chosen_port and found valid in that cycle. The receiver cannot stall.
// Sequence: the table is updated (all servers in parallel), then the scan
// comparator visits the servers one at a time, then the result is presented.
// Items do not overlap: busy is high from the update through the scan, and
// a new item may be accepted in the cycle done is high.
// Configuration: cfg_we, cfg_index, cfg_data; index 0 timeout, 1 load
// ceiling, 2 port base. Write only while no item is in progress.
// Reset: all servers alive with load 0 and age 0, none heard; registers
// return to timeout 5, ceiling 666666, port base 10000.
`default_nettype none
module least_loaded_server_selector (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	output logic                                   done,
	input  wire logic                              cfg_we,
	input  wire logic [llss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [llss_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic [llss_pkg::TYPE_W-1:0]       req_type,
	input  wire logic [llss_pkg::INDEX_W-1:0]      server_index,
	input  wire logic [llss_pkg::LOAD_W-1:0]       reported_load,
	output logic      [llss_pkg::INDEX_W-1:0]      chosen_server,
	output logic      [llss_pkg::PORT_W-1:0]       chosen_port,
	output logic                                   found
);

	llss_pkg::cmd_t cmd;
	llss_pkg::sts_t sts;

	llss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	llss_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req_type      (req_type),
		.server_index  (server_index),
		.reported_load (reported_load),
		.chosen_server (chosen_server),
		.chosen_port   (chosen_port),
		.found         (found)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(llss_pkg::LATENCY) done)
		else $error("result strobe missing after item");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("not busy after item accepted");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_none_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> chosen_server == '0)
		else $error("nonzero index with no server found");

endmodule
`default_nettype wire

// File: design/llss_ctrl.sv
`default_nettype none
module llss_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire llss_pkg::sts_t sts,
	output llss_pkg::cmd_t     cmd,
	output logic               busy,
	output logic               done
);

	llss_pkg::state_t state_q;
	llss_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= llss_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd = '0;
		busy = 1'b0;
		done = 1'b0;
		unique case (state_q)
			llss_pkg::ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_next = llss_pkg::ST_UPDATE;
				end
			end
			llss_pkg::ST_UPDATE: begin
				busy = 1'b1;
				cmd.apply = 1'b1;
				state_next = llss_pkg::ST_SCAN;
			end
			llss_pkg::ST_SCAN: begin
				busy = 1'b1;
				cmd.step = 1'b1;
				if (sts.scan_last) begin
					state_next = llss_pkg::ST_OUT;
				end
			end
			llss_pkg::ST_OUT: begin
				done = 1'b1;
				if (start) begin
					cmd.capture = 1'b1;
					state_next = llss_pkg::ST_UPDATE;
				end else begin
					state_next = llss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = llss_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: design/llss_dp.sv
`default_nettype none
module llss_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire llss_pkg::cmd_t                    cmd,
	output llss_pkg::sts_t                         sts,
	input  wire logic                              cfg_we,
	input  wire logic [llss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [llss_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic [llss_pkg::TYPE_W-1:0]       req_type,
	input  wire logic [llss_pkg::INDEX_W-1:0]      server_index,
	input  wire logic [llss_pkg::LOAD_W-1:0]       reported_load,
	output logic      [llss_pkg::INDEX_W-1:0]      chosen_server,
	output logic      [llss_pkg::PORT_W-1:0]       chosen_port,
	output logic                                   found
);

	logic [llss_pkg::AGE_W-1:0]  timeout_q;
	logic [llss_pkg::LOAD_W-1:0] ceiling_q;
	logic [llss_pkg::PORT_W-1:0] port_base_q;

	logic [llss_pkg::TYPE_W-1:0]  req_q;
	logic [llss_pkg::INDEX_W-1:0] srv_q;
	logic [llss_pkg::LOAD_W-1:0]  rep_load_q;

	logic                        alive_q [llss_pkg::NUM_SERVERS];
	logic                        heard_q [llss_pkg::NUM_SERVERS];
	logic [llss_pkg::LOAD_W-1:0] load_q  [llss_pkg::NUM_SERVERS];
	logic [llss_pkg::AGE_W-1:0]  age_q   [llss_pkg::NUM_SERVERS];

	logic                        alive_d [llss_pkg::NUM_SERVERS];
	logic                        heard_d [llss_pkg::NUM_SERVERS];
	logic [llss_pkg::LOAD_W-1:0] load_d  [llss_pkg::NUM_SERVERS];
	logic [llss_pkg::AGE_W-1:0]  age_d   [llss_pkg::NUM_SERVERS];

	logic [llss_pkg::SCAN_W-1:0] cnt_q;
	logic [llss_pkg::LOAD_W-1:0] best_q;
	logic [llss_pkg::SCAN_W-1:0] pick_q;
	logic                        hit_q;
	logic                        better;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= llss_pkg::TIMEOUT_RESET;
			ceiling_q <= llss_pkg::CEILING_RESET;
			port_base_q <= llss_pkg::PORT_BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				llss_pkg::REG_TIMEOUT: begin
					timeout_q <= cfg_data[llss_pkg::AGE_W-1:0];
				end
				llss_pkg::REG_CEILING: begin
					ceiling_q <= cfg_data[llss_pkg::LOAD_W-1:0];
				end
				llss_pkg::REG_PORT_BASE: begin
					port_base_q <= cfg_data[llss_pkg::PORT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_type;
			srv_q <= server_index;
			rep_load_q <= reported_load;
		end
	end

	always_comb begin
		for (int i = 0; i < llss_pkg::NUM_SERVERS; i++) begin
			alive_d[i] = alive_q[i];
			heard_d[i] = heard_q[i];
			load_d[i] = load_q[i];
			age_d[i] = age_q[i];
			if (req_q == llss_pkg::REQ_HEARTBEAT) begin
				if (32'(srv_q) == i) begin
					alive_d[i] = 1'b1;
					heard_d[i] = 1'b1;
					load_d[i] = rep_load_q;
					age_d[i] = '0;
				end
			end else if (heard_q[i]) begin
				if (age_q[i] != llss_pkg::AGE_MAX) begin
					age_d[i] = age_q[i] + 8'd1;
				end
				if (age_d[i] > timeout_q) begin
					alive_d[i] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < llss_pkg::NUM_SERVERS; i++) begin
				alive_q[i] <= 1'b1;
				heard_q[i] <= 1'b0;
				load_q[i] <= '0;
				age_q[i] <= '0;
			end
		end else if (cmd.apply) begin
			for (int i = 0; i < llss_pkg::NUM_SERVERS; i++) begin
				alive_q[i] <= alive_d[i];
				heard_q[i] <= heard_d[i];
				load_q[i] <= load_d[i];
				age_q[i] <= age_d[i];
			end
		end
	end

	assign better = alive_q[cnt_q] && (load_q[cnt_q] < best_q);
	assign sts.scan_last = (cnt_q == llss_pkg::SCAN_W'(llss_pkg::NUM_SERVERS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			best_q <= '0;
			pick_q <= '0;
			hit_q <= 1'b0;
		end else if (cmd.apply) begin
			cnt_q <= '0;
			best_q <= ceiling_q;
			pick_q <= '0;
			hit_q <= 1'b0;
		end else if (cmd.step) begin
			if (!sts.scan_last) begin
				cnt_q <= cnt_q + llss_pkg::SCAN_W'(1);
			end
			if (better) begin
				best_q <= load_q[cnt_q];
				pick_q <= cnt_q;
				hit_q <= 1'b1;
			end
		end
	end

	assign chosen_server = llss_pkg::INDEX_W'(pick_q);
	assign chosen_port = port_base_q + llss_pkg::PORT_W'(pick_q);
	assign found = hit_q;

endmodule
`default_nettype wire
